>>> src/tlmfmt_pkg.sv
`timescale 1ns / 1ps

package tlmfmt_pkg;

  // ascii codes used in the frame
  localparam logic [6:0] CharHash  = 7'h23;
  localparam logic [6:0] CharColon = 7'h3A;
  localparam logic [6:0] CharNorth = 7'h4E;
  localparam logic [6:0] CharSouth = 7'h53;
  localparam logic [6:0] CharEast  = 7'h45;
  localparam logic [6:0] CharWest  = 7'h57;
  localparam logic [6:0] CharDot   = 7'h2E;
  localparam logic [6:0] CharQuest = 7'h3F;

  localparam int FrameLen  = 41;
  localparam int FracDigits = 6;

  // input field widths
  localparam int LatBits   = 27;
  localparam int LonBits   = 30;
  localparam int RpmBits   = 14;
  localparam int SpeedBits = 10;
  localparam int LoadBits  = 10;

  // digit counts
  localparam int LatDigits   = 8;
  localparam int LonDigits   = 9;
  localparam int RpmDigits   = 4;
  localparam int SpeedDigits = 3;
  localparam int LoadDigits  = 3;

  // saturation limits
  localparam logic [LatBits-1:0]   LatMax   = 27'd99999999;
  localparam logic [LonBits-1:0]   LonMax   = 30'd999999999;
  localparam logic [RpmBits-1:0]   RpmMax   = 14'd9999;
  localparam logic [SpeedBits-1:0] SpeedMax = 10'd999;
  localparam logic [LoadBits-1:0]  LoadMax  = 10'd999;

  localparam int InDataBits  = 96;
  localparam int OutDataBits = 8;

  // one record with every field already saturated
  typedef struct packed {
    logic [LatBits-1:0]   lat;
    logic [LonBits-1:0]   lon;
    logic [RpmBits-1:0]   rpm;
    logic [SpeedBits-1:0] speed;
    logic [LoadBits-1:0]  load;
    logic                 north;
    logic                 east;
  } tlm_rec_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    return {3'b011, d};
  endfunction

endpackage

>>> src/tlmfmt_conv.sv
`timescale 1ns / 1ps

module tlmfmt_conv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tlmfmt_pkg::InDataBits-1:0] in_data_i,
  output logic                              rec_valid_o,
  input  logic                              rec_take_i,
  output tlmfmt_pkg::tlm_rec_t              rec_o
);
  import tlmfmt_pkg::*;

  // field offsets in tdata
  localparam int LatLo   = 0;
  localparam int NorthLo = LatLo + LatBits;
  localparam int LonLo   = NorthLo + 1;
  localparam int EastLo  = LonLo + LonBits;
  localparam int RpmLo   = EastLo + 1;
  localparam int SpeedLo = RpmLo + RpmBits;
  localparam int LoadLo  = SpeedLo + SpeedBits;

  logic     full_q, full_d;
  tlm_rec_t rec_q, rec_d;

  logic [LatBits-1:0]   lat_in;
  logic [LonBits-1:0]   lon_in;
  logic [RpmBits-1:0]   rpm_in;
  logic [SpeedBits-1:0] spd_in;
  logic [LoadBits-1:0]  load_in;
  logic                 accept;

  assign in_ready_o = !full_q;
  assign accept     = in_valid_i && in_ready_o;

  // fields above their maximum print as all nines
  always_comb begin
    lat_in  = in_data_i[LatLo +: LatBits];
    lon_in  = in_data_i[LonLo +: LonBits];
    rpm_in  = in_data_i[RpmLo +: RpmBits];
    spd_in  = in_data_i[SpeedLo +: SpeedBits];
    load_in = in_data_i[LoadLo +: LoadBits];
    if (lat_in > LatMax)    lat_in  = LatMax;
    if (lon_in > LonMax)    lon_in  = LonMax;
    if (rpm_in > RpmMax)    rpm_in  = RpmMax;
    if (spd_in > SpeedMax)  spd_in  = SpeedMax;
    if (load_in > LoadMax)  load_in = LoadMax;
  end

  always_comb begin
    full_d = full_q;
    rec_d  = rec_q;
    if (rec_take_i) begin
      full_d = 1'b0;
    end
    if (accept) begin
      full_d      = 1'b1;
      rec_d.lat   = lat_in;
      rec_d.north = in_data_i[NorthLo];
      rec_d.lon   = lon_in;
      rec_d.east  = in_data_i[EastLo];
      rec_d.rpm   = rpm_in;
      rec_d.speed = spd_in;
      rec_d.load  = load_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_valid_o = full_q;
  assign rec_o       = rec_q;

endmodule

>>> src/tlmfmt_emit.sv
`timescale 1ns / 1ps

module tlmfmt_emit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rec_valid_i,
  output logic                               rec_take_o,
  input  tlmfmt_pkg::tlm_rec_t               rec_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tlmfmt_pkg::OutDataBits-1:0] out_data_o,
  output logic                               out_last_o
);
  import tlmfmt_pkg::*;

  localparam int PosBits = $clog2(FrameLen);
  localparam logic [PosBits-1:0] LastPos = PosBits'(FrameLen - 1);
  localparam int ValBits = LonBits;

  logic               busy_q, busy_d;
  logic [PosBits-1:0] pos_q, pos_d;
  tlm_rec_t           rec_q, rec_d;
  logic [ValBits-1:0] rem_q, rem_d;
  logic               ov_q, ov_d;
  logic [6:0]         obyte_q, obyte_d;
  logic               olast_q, olast_d;

  logic               load_byte, last_load;
  logic [6:0]         cur_char, sym_char;
  logic               is_digit;
  logic [3:0]         dig_exp;
  logic [ValBits-1:0] dig_src, dig_part;
  logic [3:0]         dig_val;

  // d times ten to the power e, for e from 0 to 8
  function automatic logic [ValBits-1:0] weight_mul(input logic [3:0] e, input int d);
    logic [ValBits-1:0] w;
    case (e)
      4'd0:    w = ValBits'(d);
      4'd1:    w = ValBits'(d * 10);
      4'd2:    w = ValBits'(d * 100);
      4'd3:    w = ValBits'(d * 1000);
      4'd4:    w = ValBits'(d * 10000);
      4'd5:    w = ValBits'(d * 100000);
      4'd6:    w = ValBits'(d * 1000000);
      4'd7:    w = ValBits'(d * 10000000);
      4'd8:    w = ValBits'(d * 100000000);
      default: w = ValBits'(d);
    endcase
    return w;
  endfunction

  assign load_byte  = busy_q && (!ov_q || out_ready_i);
  assign last_load  = load_byte && (pos_q == LastPos);
  assign rec_take_o = rec_valid_i && (!busy_q || last_load);

  // frame position decode: fixed characters, or the place value of a digit
  always_comb begin
    sym_char = CharColon;
    is_digit = 1'b0;
    dig_exp  = '0;
    case (pos_q) inside
      6'd0:            sym_char = CharHash;
      6'd2:            sym_char = rec_q.north ? CharNorth : CharSouth;
      [6'd4:6'd5]:     begin
        is_digit = 1'b1;
        dig_exp  = 4'(6'd11 - pos_q);
      end
      6'd6, 6'd19:     sym_char = CharDot;
      [6'd7:6'd12]:    begin
        is_digit = 1'b1;
        dig_exp  = 4'(6'd12 - pos_q);
      end
      6'd14:           sym_char = rec_q.east ? CharEast : CharWest;
      [6'd16:6'd18]:   begin
        is_digit = 1'b1;
        dig_exp  = 4'(6'd24 - pos_q);
      end
      [6'd20:6'd25]:   begin
        is_digit = 1'b1;
        dig_exp  = 4'(6'd25 - pos_q);
      end
      [6'd27:6'd30]:   begin
        is_digit = 1'b1;
        dig_exp  = 4'(6'd30 - pos_q);
      end
      [6'd32:6'd34]:   begin
        is_digit = 1'b1;
        dig_exp  = 4'(6'd34 - pos_q);
      end
      [6'd36:6'd38]:   begin
        is_digit = 1'b1;
        dig_exp  = 4'(6'd38 - pos_q);
      end
      6'd1, 6'd3, 6'd13, 6'd15, 6'd26, 6'd31, 6'd35, 6'd39:
                       sym_char = CharColon;
      default:         sym_char = CharQuest;
    endcase
  end

  // each numeric field starts from its saturated value, later digits from the remainder
  always_comb begin
    case (pos_q)
      6'd4:    dig_src = ValBits'(rec_q.lat);
      6'd16:   dig_src = rec_q.lon;
      6'd27:   dig_src = ValBits'(rec_q.rpm);
      6'd32:   dig_src = ValBits'(rec_q.speed);
      6'd36:   dig_src = ValBits'(rec_q.load);
      default: dig_src = rem_q;
    endcase
  end

  // digit = largest multiple of the place value that still fits
  always_comb begin
    dig_val  = '0;
    dig_part = '0;
    for (int d = 1; d <= 9; d++) begin
      if (dig_src >= weight_mul(dig_exp, d)) begin
        dig_val  = 4'(d);
        dig_part = weight_mul(dig_exp, d);
      end
    end
  end

  assign cur_char = is_digit ? digit_char(dig_val) : sym_char;

  always_comb begin
    busy_d  = busy_q;
    pos_d   = pos_q;
    rec_d   = rec_q;
    rem_d   = rem_q;
    ov_d    = ov_q && !out_ready_i;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (load_byte) begin
      ov_d    = 1'b1;
      obyte_d = cur_char;
      olast_d = (pos_q == LastPos);
      pos_d   = pos_q + 1'b1;
      if (is_digit) begin
        rem_d = dig_src - dig_part;
      end
      if (last_load) begin
        busy_d = 1'b0;
      end
    end
    if (rec_take_o) begin
      busy_d = 1'b1;
      pos_d  = '0;
      rec_d  = rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q   <= rec_d;
    rem_q   <= rem_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {1'b0, obyte_q};
  assign out_last_o  = olast_q;

endmodule

>>> src/telemetry_ascii_frame_formatter.sv
`timescale 1ns / 1ps

// Telemetry ASCII frame formatter. Each record request on the slave stream
// becomes one 41-byte frame "#:H:DD.dddddd:G:DDD.dddddd:RRRR:VVV:LLL:?" on
// the master stream, one byte per request, tlast on the closing '?'. Values
// above a field's maximum print as all nines. An accepted record is held in
// an input register with its fields saturated; the emitter copies it and
// streams the frame at one byte per cycle while the master side accepts,
// pulling each decimal digit out most significant first by comparing
// against the nine multiples of its place value and keeping the remainder.
// The next record waits in the input register while the current frame is
// still going out, and is taken in the cycle the last byte is loaded. A
// record accepted into an idle block passes the input register and the
// emitter's record register before its first byte is registered. Back-pressure on
// the master side holds the current byte and stalls the frame in place.

module telemetry_ascii_frame_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // lat_micro[26:0], lat_is_north[27], lon_micro[57:28], lon_is_east[58],
  // rpm_value[72:59], speed_value[82:73], load_value[92:83], zero[95:93]
  input  logic [95:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // ascii_byte[6:0], zero[7]
  output logic [7:0]  m_axis_tdata_o,
  // frame_last
  output logic        m_axis_tlast_o
);
  import tlmfmt_pkg::*;

  // saturated record handed from the input register to the byte emitter
  tlm_rec_t record;
  logic     rec_valid;
  logic     rec_take;

  // input register with field saturation
  tlmfmt_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .rec_valid_o (rec_valid),
    .rec_take_i  (rec_take),
    .rec_o       (record)
  );

  // frame position counter, digit extraction and output register
  tlmfmt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_take_o  (rec_take),
    .rec_i       (record),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

>>> bench/tlmfmt_frame_checker.sv
`timescale 1ns / 1ps

module tlmfmt_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [95:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  output int          mismatch_cnt_o,
  output int          bytes_pending_o
);
  import tlmfmt_pkg::*;

  localparam logic [6:0] CharZero = 7'h30;

  typedef struct packed {
    logic [6:0] ascii;
    logic       last;
  } frame_byte_t;

  frame_byte_t frame_bytes_q[$];
  int          mismatch_cnt;

  task automatic push_char(input logic [6:0] ch, input logic last);
    frame_byte_t fb;
    fb.ascii = ch;
    fb.last  = last;
    frame_bytes_q.push_back(fb);
  endtask

  // fixed count of decimal digits, leading zeros
  task automatic push_digits(input longint unsigned v, input int ndig);
    longint unsigned scale;
    for (int i = ndig - 1; i >= 0; i--) begin
      scale = 1;
      for (int j = 0; j < i; j++) scale = scale * 10;
      push_char(CharZero + 7'((v / scale) % 10), 1'b0);
    end
  endtask

  // millionths: integer digits, dot, six fraction digits
  task automatic push_coord(input longint unsigned micro, input int int_digits);
    push_digits(micro / 1000000, int_digits);
    push_char(CharDot, 1'b0);
    push_digits(micro % 1000000, FracDigits);
  endtask

  task automatic predict_frame(input logic [95:0] word);
    logic [LatBits-1:0]   lat;
    logic [LonBits-1:0]   lon;
    logic [RpmBits-1:0]   rpm;
    logic [SpeedBits-1:0] speed;
    logic [LoadBits-1:0]  load;
    logic                 north;
    logic                 east;
    {load, speed, rpm, east, lon, north, lat} = word[92:0];
    if (lat > LatMax) lat = LatMax;
    if (lon > LonMax) lon = LonMax;
    if (rpm > RpmMax) rpm = RpmMax;
    if (speed > SpeedMax) speed = SpeedMax;
    if (load > LoadMax) load = LoadMax;
    push_char(CharHash, 1'b0);
    push_char(CharColon, 1'b0);
    push_char(north ? CharNorth : CharSouth, 1'b0);
    push_char(CharColon, 1'b0);
    push_coord(lat, LatDigits - FracDigits);
    push_char(CharColon, 1'b0);
    push_char(east ? CharEast : CharWest, 1'b0);
    push_char(CharColon, 1'b0);
    push_coord(lon, LonDigits - FracDigits);
    push_char(CharColon, 1'b0);
    push_digits(rpm, RpmDigits);
    push_char(CharColon, 1'b0);
    push_digits(speed, SpeedDigits);
    push_char(CharColon, 1'b0);
    push_digits(load, LoadDigits);
    push_char(CharColon, 1'b0);
    push_char(CharQuest, 1'b1);
  endtask

  initial begin
    mismatch_cnt    = 0;
    mismatch_cnt_o  = 0;
    bytes_pending_o = 0;
  end

  always @(posedge clk_i) begin
    frame_byte_t exp_b;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) predict_frame(s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (frame_bytes_q.size() == 0) begin
          $error("unexpected byte: ascii_byte actual %h, frame_last actual %b",
                 m_axis_tdata_i[6:0], m_axis_tlast_i);
          mismatch_cnt++;
        end else begin
          exp_b = frame_bytes_q.pop_front();
          if (m_axis_tdata_i[6:0] !== exp_b.ascii) begin
            $error("ascii_byte: expected %h actual %h", exp_b.ascii, m_axis_tdata_i[6:0]);
            mismatch_cnt++;
          end
          if (m_axis_tlast_i !== exp_b.last) begin
            $error("frame_last: expected %b actual %b", exp_b.last, m_axis_tlast_i);
            mismatch_cnt++;
          end
          if (m_axis_tdata_i[7] !== 1'b0) begin
            $error("tdata pad: expected 0 actual %b", m_axis_tdata_i[7]);
            mismatch_cnt++;
          end
        end
      end
    end
    mismatch_cnt_o  <= mismatch_cnt;
    bytes_pending_o <= frame_bytes_q.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import tlmfmt_pkg::*;

  // long receiver hold-off and an idle-free window, in cycles after reset
  localparam int HoldStart   = 2500;
  localparam int HoldLen     = 400;
  localparam int QuietStart  = 6000;
  localparam int QuietEnd    = 8000;
  localparam int RandRecords = 260;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // lat_micro, lat_is_north, lon_micro, lon_is_east, rpm, speed, load, zero pad
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // ascii_byte[6:0], zero[7]
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  int          mismatch_cnt;
  int          bytes_pending;

  telemetry_ascii_frame_formatter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // predicts each frame from the accepted record and compares byte by byte
  tlmfmt_frame_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .mismatch_cnt_o  (mismatch_cnt),
    .bytes_pending_o (bytes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // pack one record the way the slave tdata expects it, low field first
  function automatic logic [95:0] pack_record(input int unsigned lat, input bit north,
                                              input int unsigned lon, input bit east,
                                              input int unsigned rpm, input int unsigned speed,
                                              input int unsigned load);
    return {3'b000, LoadBits'(load), SpeedBits'(speed), RpmBits'(rpm), east,
            LonBits'(lon), north, LatBits'(lat)};
  endfunction

  // mostly in range, some above the field maximum, some raw bits, some edges
  function automatic int unsigned pick_value(input int unsigned max_val, input int width);
    int unsigned full;
    int unsigned sel;
    full = (1 << width) - 1;
    sel  = $urandom_range(19);
    if (sel < 12) return $urandom_range(max_val);
    if (sel < 15) return $urandom_range(full, max_val + 1);
    if (sel < 18) return $urandom & full;
    if (sel == 18) return max_val;
    return max_val + 1;
  endfunction

  function automatic logic [95:0] random_record();
    return pack_record(pick_value(LatMax, LatBits), $urandom_range(1),
                       pick_value(LonMax, LonBits), $urandom_range(1),
                       pick_value(RpmMax, RpmBits), pick_value(SpeedMax, SpeedBits),
                       pick_value(LoadMax, LoadBits));
  endfunction

  // one record request; the gap in front of it is optional
  task automatic send_record(input logic [95:0] word, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(99) < 25) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and let every predicted byte come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (bytes_pending != 0);
  endtask

  // receiver: random back-pressure, one long hold-off so the input stalls,
  // and a window with no idling at all
  initial begin
    int cyc;
    m_axis_tready = 1'b0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen) m_axis_tready <= 1'b0;
      else if (cyc >= QuietStart && cyc < QuietEnd) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(99) >= 10);
    end
  end

  // stimulus and verdict
  initial begin
    logic [95:0] directed_q[$];
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // zeros, maxima, just above maxima, all ones, every hemisphere
    directed_q.push_back(pack_record(0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(pack_record(LatMax, 1, LonMax, 1, RpmMax, SpeedMax, LoadMax));
    directed_q.push_back(pack_record(LatMax + 1, 1, LonMax + 1, 0, RpmMax + 1,
                                     SpeedMax + 1, LoadMax + 1));
    directed_q.push_back(pack_record((1 << LatBits) - 1, 0, (1 << LonBits) - 1, 1,
                                     (1 << RpmBits) - 1, (1 << SpeedBits) - 1,
                                     (1 << LoadBits) - 1));
    directed_q.push_back(pack_record(LatMax, 1, 0, 0, 0, 0, 0));
    directed_q.push_back(pack_record(LatMax + 1, 0, 0, 1, 0, 0, 0));
    directed_q.push_back(pack_record(0, 0, LonMax, 1, 0, 0, 0));
    directed_q.push_back(pack_record(0, 1, LonMax + 1, 0, 0, 0, 0));
    // counters at, just above and far above their maxima
    directed_q.push_back(pack_record(0, 1, 0, 1, RpmMax, SpeedMax + 1, (1 << LoadBits) - 1));
    directed_q.push_back(pack_record(0, 0, 0, 0, RpmMax + 1, (1 << SpeedBits) - 1, LoadMax));
    directed_q.push_back(pack_record(0, 1, 0, 0, (1 << RpmBits) - 1, SpeedMax, LoadMax + 1));
    // digit ordering and fraction boundaries
    directed_q.push_back(pack_record(12345678, 1, 123456789, 1, 1234, 567, 890));
    directed_q.push_back(pack_record(999999, 0, 1000000, 1, 1, 10, 100));
    directed_q.push_back(pack_record(1000000, 1, 999999, 0, 9000, 900, 9));
    directed_q.push_back(pack_record(1, 0, 1, 0, 10, 1, 99));
    directed_q.push_back(pack_record(90000000, 1, 180000000, 0, 5000, 250, 500));
    foreach (directed_q[i]) send_record(directed_q[i], 1'b1);

    // sender pause: everything in flight must come out first
    wait_drained();

    // random records, a stretch of them sent back to back
    for (int n = 0; n < RandRecords; n++) begin
      send_record(random_record(), !(n >= 100 && n < 160));
      if (n == 200) wait_drained();
    end
    wait_drained();

    // a few more cycles in case the block sends anything extra
    repeat (64) @(negedge clk_i);
    if (mismatch_cnt == 0 && bytes_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
